// File: sv/aae_pkg.sv
package aae_pkg;

   // Sponge geometry and round counts of Ascon-128a.
   localparam int INIT_ROUNDS  = 12;
   localparam int BLOCK_ROUNDS = 8;
   localparam int RATE_BYTES   = 128 / 8;
   localparam int MAX_ROUNDS   = 12;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // Initial value of the first sponge word.
   localparam logic [63:0] ASCON_IV = {8'd128, 8'(8 * RATE_BYTES), 8'(INIT_ROUNDS),
                                       8'(BLOCK_ROUNDS), 32'h0};

   // First round index of each permutation length.
   localparam logic [3:0] INIT_START  = 4'(MAX_ROUNDS - INIT_ROUNDS);
   localparam logic [3:0] BLOCK_START = 4'(MAX_ROUNDS - BLOCK_ROUNDS);
   localparam logic [3:0] LAST_ROUND  = 4'(MAX_ROUNDS - 1);

   // Input operation codes.
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_AD    = 2'd1;
   localparam logic [1:0] OP_TEXT  = 2'd2;

   // Result kinds.
   localparam logic KIND_CIPHER = 1'b0;
   localparam logic KIND_TAG    = 1'b1;

   // Message phases.
   localparam logic [1:0] PHASE_IDLE = 2'd0;
   localparam logic [1:0] PHASE_AD   = 2'd1;
   localparam logic [1:0] PHASE_MSG  = 2'd2;

   // Five big-endian sponge words, word 0 first.
   typedef logic [0:4][63:0] aae_state_type;

   function automatic logic [63:0] rotr64(input logic [63:0] v, input int unsigned r);
      return (v >> r) | (v << (64 - r));
   endfunction

   // Mask covering the first n bytes of a big-endian 16-byte block.
   function automatic logic [127:0] lead_mask(input logic [4:0] n);
      logic [127:0] m;
      m = '0;
      for (int i = 0; i < RATE_BYTES; i++) begin
         if (5'(i) < n) begin
            m[127 - 8 * i -: 8] = 8'hff;
         end
      end
      return m;
   endfunction

   // Padding byte placed directly after the first n bytes (n below 16).
   function automatic logic [127:0] pad_block(input logic [4:0] n);
      logic [127:0] p;
      p = '0;
      for (int i = 0; i < RATE_BYTES; i++) begin
         if (5'(i) == n) begin
            p[127 - 8 * i -: 8] = PAD_BYTE;
         end
      end
      return p;
   endfunction

endpackage

// File: sv/ascon_aead_encrypt.sv
// Ascon-128a authenticated encryption of one message at a time under the
// 128-bit key written through the csr_ port (index 0 the high key word, index
// 1 the low one; write it only while the block is idle). Send a start
// transaction carrying the nonce, then associated-data blocks of 16 bytes
// ending with one shorter (padded) block, then plaintext blocks of 16 bytes
// ending with one of 0 to 15 bytes. Every plaintext block returns one
// ciphertext transaction; the final one is followed by the tag transaction,
// which has last set. Out-of-order transactions are dropped without effect,
// and a start always begins a fresh message. A single round unit runs one
// permutation round per clock, so the block accepts a transaction, absorbs it
// in the EXEC state, then runs its rounds in the PERM state; a dropped
// transaction returns to idle straight from EXEC, and after the final
// plaintext block the tag passes through the TAG state into the output
// register. The ciphertext and the tag leave through one output register;
// the block keeps working while a result waits there and only pauses when
// it needs the register for the next result.
module ascon_aead_encrypt
   import aae_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_word_high,
   input  logic [63:0] req_word_low,
   input  logic [4:0]  req_byte_count,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [63:0] rsp_out_high,
   output logic [63:0] rsp_out_low,
   output logic [4:0]  rsp_out_count,
   output logic        rsp_last
);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_PERM = 2'd2;
   localparam logic [1:0] ST_TAG  = 2'd3;

   // What happens after the last round of a permutation.
   localparam logic [1:0] POST_NONE = 2'd0;
   localparam logic [1:0] POST_KEY  = 2'd1;
   localparam logic [1:0] POST_DSEP = 2'd2;
   localparam logic [1:0] POST_TAG  = 2'd3;

   logic [63:0]   key_high_ff, key_low_ff;
   aae_state_type sponge_ff, sponge_in;
   logic [1:0]    state_ff, state_in;
   logic [1:0]    phase_ff, phase_in;
   logic [1:0]    post_ff, post_in;
   logic [3:0]    rnd_ff, rnd_in;

   // The accepted transaction, with stray bytes of a data block already cleared.
   logic [1:0]    op_ff;
   logic [127:0]  data_ff;
   logic [4:0]    count_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic [63:0]   rsp_high_ff, rsp_high_in;
   logic [63:0]   rsp_low_ff, rsp_low_in;
   logic [4:0]    rsp_count_ff, rsp_count_in;
   logic          rsp_last_ff, rsp_last_in;

   aae_state_type round_out;
   logic [4:0]    req_count_clamped;
   logic          out_free;
   logic          accept;
   logic [127:0]  absorbed;
   logic          partial;

   aae_round u_round (
      .state_in    (sponge_ff),
      .round_index (rnd_ff),
      .state_out   (round_out)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Byte counts beyond one block are taken as a full block.
   assign req_count_clamped = (req_byte_count > 5'(RATE_BYTES)) ? 5'(RATE_BYTES)
                                                                : req_byte_count;

   // The output register can take a new result this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Rate part after xoring in the block, with padding on a short block.
   assign partial  = (count_ff < 5'(RATE_BYTES));
   assign absorbed = {sponge_ff[0], sponge_ff[1]} ^ data_ff
                     ^ (partial ? pad_block(count_ff) : 128'h0);

   always_comb begin
      sponge_in    = sponge_ff;
      state_in     = state_ff;
      phase_in     = phase_ff;
      post_in      = post_ff;
      rnd_in       = rnd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_high_in  = rsp_high_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_IDLE;
            if (op_ff == OP_START) begin
               // Load IV, key and nonce; the key is folded in again afterwards.
               sponge_in = {ASCON_IV, key_high_ff, key_low_ff, data_ff[127:64],
                            data_ff[63:0]};
               rnd_in    = INIT_START;
               post_in   = POST_KEY;
               phase_in  = PHASE_AD;
               state_in  = ST_PERM;
            end else if (op_ff == OP_AD && phase_ff == PHASE_AD) begin
               sponge_in[0] = absorbed[127:64];
               sponge_in[1] = absorbed[63:0];
               rnd_in       = BLOCK_START;
               post_in      = partial ? POST_DSEP : POST_NONE;
               if (partial) begin
                  phase_in = PHASE_MSG;
               end
               state_in = ST_PERM;
            end else if (op_ff == OP_TEXT && phase_ff != PHASE_IDLE) begin
               if (!out_free) begin
                  // Hold everything until the previous result has been taken.
                  state_in = ST_EXEC;
               end else begin
                  sponge_in[0] = absorbed[127:64];
                  sponge_in[1] = absorbed[63:0];
                  // Domain separation is still owed on the first plaintext block.
                  sponge_in[4][0] = sponge_ff[4][0] ^ (phase_ff == PHASE_AD);
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_CIPHER;
                  rsp_last_in  = 1'b0;
                  rsp_count_in = count_ff;
                  if (partial) begin
                     {rsp_high_in, rsp_low_in} = absorbed & lead_mask(count_ff);
                     sponge_in[2] = sponge_ff[2] ^ key_high_ff;
                     sponge_in[3] = sponge_ff[3] ^ key_low_ff;
                     rnd_in       = INIT_START;
                     post_in      = POST_TAG;
                     phase_in     = PHASE_IDLE;
                  end else begin
                     {rsp_high_in, rsp_low_in} = absorbed;
                     rnd_in   = BLOCK_START;
                     post_in  = POST_NONE;
                     phase_in = PHASE_MSG;
                  end
                  state_in = ST_PERM;
               end
            end
         end

         ST_PERM: begin
            sponge_in = round_out;
            rnd_in    = rnd_ff + 4'd1;
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_IDLE;
               case (post_ff)
                  POST_KEY: begin
                     sponge_in[3] = round_out[3] ^ key_high_ff;
                     sponge_in[4] = round_out[4] ^ key_low_ff;
                  end
                  POST_DSEP: begin
                     sponge_in[4][0] = ~round_out[4][0];
                  end
                  POST_TAG: begin
                     sponge_in[3] = round_out[3] ^ key_high_ff;
                     sponge_in[4] = round_out[4] ^ key_low_ff;
                     state_in     = ST_TAG;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_TAG: begin
            // The tag follows the final ciphertext through the output register.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_TAG;
               rsp_high_in  = sponge_ff[3];
               rsp_low_in   = sponge_ff[4];
               rsp_count_in = 5'(RATE_BYTES);
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff  <= '0;
         key_low_ff   <= '0;
         sponge_ff    <= '0;
         state_ff     <= ST_IDLE;
         phase_ff     <= PHASE_IDLE;
         post_ff      <= POST_NONE;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == 1'b0) begin
               key_high_ff <= csr_wdata;
            end else begin
               key_low_ff <= csr_wdata;
            end
         end
         sponge_ff    <= sponge_in;
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         post_ff      <= post_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         count_ff <= req_count_clamped;
         // A start keeps the whole nonce.
         if (req_op == OP_START) begin
            data_ff <= {req_word_high, req_word_low};
         end else begin
            data_ff <= {req_word_high, req_word_low} & lead_mask(req_count_clamped);
         end
      end
      rsp_kind_ff  <= rsp_kind_in;
      rsp_high_ff  <= rsp_high_in;
      rsp_low_ff   <= rsp_low_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_out_high  = rsp_high_ff;
   assign rsp_out_low   = rsp_low_ff;
   assign rsp_out_count = rsp_count_ff;
   assign rsp_last      = rsp_last_ff;

   // An accepted transaction always brings the block into its EXEC state in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted transaction was not absorbed");

   // The round counter never runs past the final round of a permutation.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PERM |-> rnd_ff <= LAST_ROUND)
      else $error("round index out of range");

   // A tag is always marked as the end of the message, ciphertext never.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_last_ff == (rsp_kind_ff == KIND_TAG))
      else $error("last flag does not match result kind");

   // Waiting to send the tag means the message phase has already closed.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TAG |-> phase_ff == PHASE_IDLE)
      else $error("tag pending while message still open");

endmodule

// File: sv/aae_round.sv
module aae_round
   import aae_pkg::*;
(
   input  aae_state_type state_in,
   input  logic [3:0]    round_index,
   output aae_state_type state_out
);

   // One Ascon permutation round: constant addition, S-box layer, linear layer.
   always_comb begin
      logic [63:0] a0, a1, a2, a3, a4;
      logic [63:0] b0, b1, b2, b3, b4;
      a0 = state_in[0];
      a1 = state_in[1];
      a2 = state_in[2];
      a3 = state_in[3];
      a4 = state_in[4];
      a2 = a2 ^ {56'h0, 4'hf - round_index, round_index};
      a0 = a0 ^ a4;
      a4 = a4 ^ a3;
      a2 = a2 ^ a1;
      b0 = ~a0 & a1;
      b1 = ~a1 & a2;
      b2 = ~a2 & a3;
      b3 = ~a3 & a4;
      b4 = ~a4 & a0;
      a0 = a0 ^ b1;
      a1 = a1 ^ b2;
      a2 = a2 ^ b3;
      a3 = a3 ^ b4;
      a4 = a4 ^ b0;
      a1 = a1 ^ a0;
      a0 = a0 ^ a4;
      a3 = a3 ^ a2;
      a2 = ~a2;
      state_out[0] = a0 ^ rotr64(a0, 19) ^ rotr64(a0, 28);
      state_out[1] = a1 ^ rotr64(a1, 61) ^ rotr64(a1, 39);
      state_out[2] = a2 ^ rotr64(a2, 1) ^ rotr64(a2, 6);
      state_out[3] = a3 ^ rotr64(a3, 10) ^ rotr64(a3, 17);
      state_out[4] = a4 ^ rotr64(a4, 7) ^ rotr64(a4, 41);
   end

endmodule

// File: dv/tb_top.sv
module tb_top
   import aae_pkg::*;
();

   // The block runs at most twelve rounds, so the last round index is eleven.
   localparam int HALF_PERIOD   = 2;
   localparam int RESET_CYCLES  = 11;
   // The settle time outlasts the work of a start and of the final text block,
   // so after it the block is sure to have gone idle.
   localparam int SETTLE_CYCLES = 20;
   localparam int TAIL_CYCLES   = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 3000;
   localparam int ITEM_TARGET   = 1200;
   localparam int MAX_REPORTS   = 100;

   // Register indexes of the key words, and the op code that the block never uses.
   localparam logic       REG_KEY_HIGH = 1'b0;
   localparam logic       REG_KEY_LOW  = 1'b1;
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   // IV of Ascon-128a: key size, rate in bits, initial rounds and block rounds.
   localparam logic [63:0] ASCON128A_IV = 64'h8080_0c08_0000_0000;

   typedef struct packed {
      logic        kind;
      logic [63:0] high;
      logic [63:0] low;
      logic [4:0]  count;
      logic        last;
   } enc_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [63:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_op;
   logic [63:0] req_word_high;
   logic [63:0] req_word_low;
   logic [4:0]  req_byte_count;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_kind;
   logic [63:0] rsp_out_high;
   logic [63:0] rsp_out_low;
   logic [4:0]  rsp_out_count;
   logic        rsp_last;

   // Our own copy of the sponge, the message phase and the key.
   aae_state_type sponge;
   logic [1:0]    msg_phase;
   logic [63:0]   key_hi;
   logic [63:0]   key_lo;

   // Ciphertext and tag transactions predicted but not yet seen, oldest first.
   enc_result_type awaited_ct[$];

   int unsigned mismatches        = 0;
   int unsigned well_formed_items = 0;
   int unsigned quiet_cycles      = 0;

   // When steady_flow is set neither side inserts idle cycles. When hold_output
   // is set the result sink holds rsp_ready low for a long stretch and then
   // clears the flag itself.
   bit steady_flow = 1'b0;
   bit hold_output = 1'b0;

   ascon_aead_encrypt DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_word_high  (req_word_high),
      .req_word_low   (req_word_low),
      .req_byte_count (req_byte_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_out_high   (rsp_out_high),
      .rsp_out_low    (rsp_out_low),
      .rsp_out_count  (rsp_out_count),
      .rsp_last       (rsp_last)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // Right rotation done by shifting a doubled copy of the word.
   function automatic logic [63:0] ror64(input logic [63:0] v, input int unsigned r);
      logic [127:0] twice;
      twice = {v, v} >> r;
      return twice[63:0];
   endfunction

   // The Ascon permutation: the last 'rounds' of the twelve rounds, each one a
   // constant addition, the five-bit S-box across the words and the linear layer.
   function automatic aae_state_type ascon_permute(input aae_state_type s,
                                                   input int rounds);
      logic [63:0] a0, a1, a2, a3, a4;
      logic [63:0] t0, t1, t2, t3, t4;
      a0 = s[0];
      a1 = s[1];
      a2 = s[2];
      a3 = s[3];
      a4 = s[4];
      for (int r = MAX_ROUNDS - rounds; r < MAX_ROUNDS; r++) begin
         a2 ^= 64'(((15 - r) << 4) | r);
         a0 ^= a4;
         a4 ^= a3;
         a2 ^= a1;
         t0 = ~a0 & a1;
         t1 = ~a1 & a2;
         t2 = ~a2 & a3;
         t3 = ~a3 & a4;
         t4 = ~a4 & a0;
         a0 ^= t1;
         a1 ^= t2;
         a2 ^= t3;
         a3 ^= t4;
         a4 ^= t0;
         a1 ^= a0;
         a0 ^= a4;
         a3 ^= a2;
         a2 = ~a2;
         a0 ^= ror64(a0, 19) ^ ror64(a0, 28);
         a1 ^= ror64(a1, 61) ^ ror64(a1, 39);
         a2 ^= ror64(a2, 1) ^ ror64(a2, 6);
         a3 ^= ror64(a3, 10) ^ ror64(a3, 17);
         a4 ^= ror64(a4, 7) ^ ror64(a4, 41);
      end
      return {a0, a1, a2, a3, a4};
   endfunction

   // Keeps the first n bytes of a big-endian 16-byte block.
   function automatic logic [127:0] byte_keep(input int unsigned n);
      return (n == 0) ? 128'd0 : ~128'd0 << (8 * (RATE_BYTES - n));
   endfunction

   // Works out what one accepted transaction does to the sponge and queues the
   // ciphertext and tag that it should produce.
   task automatic ascon_encrypt_step(input logic [1:0] op, input logic [63:0] hi,
                                     input logic [63:0] lo, input logic [4:0] count);
      int unsigned  n;
      logic [127:0] keep;
      logic [127:0] blk;
      logic [127:0] rate;
      n    = (count > 5'(RATE_BYTES)) ? RATE_BYTES : count;
      keep = byte_keep(n);
      // Bytes at or beyond the count are cleared before they are absorbed.
      blk  = {hi, lo} & keep;
      if (n != RATE_BYTES) begin
         blk ^= 128'(PAD_BYTE) << (8 * (RATE_BYTES - 1 - n));
      end
      case (op)
         OP_START: begin
            // A start always reinitialises, whatever was in progress.
            sponge = {ASCON128A_IV, key_hi, key_lo, hi, lo};
            sponge = ascon_permute(sponge, INIT_ROUNDS);
            sponge[3] ^= key_hi;
            sponge[4] ^= key_lo;
            msg_phase = PHASE_AD;
         end
         OP_AD: begin
            if (msg_phase == PHASE_AD) begin
               sponge[0] ^= blk[127:64];
               sponge[1] ^= blk[63:0];
               sponge = ascon_permute(sponge, BLOCK_ROUNDS);
               // A short block closes the associated data and separates domains.
               if (n != RATE_BYTES) begin
                  sponge[4] ^= 64'd1;
                  msg_phase = PHASE_MSG;
               end
            end
         end
         OP_TEXT: begin
            if (msg_phase != PHASE_IDLE) begin
               if (msg_phase == PHASE_AD) begin
                  sponge[4] ^= 64'd1;
                  msg_phase = PHASE_MSG;
               end
               sponge[0] ^= blk[127:64];
               sponge[1] ^= blk[63:0];
               rate = {sponge[0], sponge[1]} & keep;
               awaited_ct.push_back(enc_result_type'{KIND_CIPHER, rate[127:64], rate[63:0],
                                                     5'(n), 1'b0});
               if (n == RATE_BYTES) begin
                  sponge = ascon_permute(sponge, BLOCK_ROUNDS);
               end else begin
                  sponge[2] ^= key_hi;
                  sponge[3] ^= key_lo;
                  sponge = ascon_permute(sponge, INIT_ROUNDS);
                  sponge[3] ^= key_hi;
                  sponge[4] ^= key_lo;
                  awaited_ct.push_back(enc_result_type'{KIND_TAG, sponge[3], sponge[4],
                                                        5'(RATE_BYTES), 1'b1});
                  msg_phase = PHASE_IDLE;
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // Driving the block
   // ---------------------------------------------------------------------------

   // Random word, now and then all zeros or all ones.
   function automatic logic [63:0] rand64();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Count of a full block; counts above sixteen are clamped by the block.
   function automatic logic [4:0] full_count();
      return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(17, 31)) : 5'(RATE_BYTES);
   endfunction

   // Offers one transaction, with a random idle gap first, and holds it until it
   // is accepted. Valid is only lowered when a gap is inserted, so it is never
   // lowered and raised again within one time step.
   task automatic send_block(input logic [1:0] op, input logic [63:0] hi,
                             input logic [63:0] lo, input logic [4:0] count);
      int unsigned gap;
      gap = 0;
      if (!steady_flow) begin
         while ($urandom_range(0, 99) < 16) gap++;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_word_high  <= hi;
      req_word_low   <= lo;
      req_byte_count <= count;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ascon_encrypt_step(op, hi, lo, count);
   endtask

   // A transaction of any code and any count, often out of order.
   task automatic send_noise();
      send_block(2'($urandom_range(OP_START, OP_UNUSED)), rand64(), rand64(),
                 5'($urandom_range(0, 31)));
   endtask

   // Stops offering, waits for every predicted result and then lets the block
   // finish any work that produces no result.
   task automatic wait_for_results(input int unsigned settle);
      req_valid <= 1'b0;
      while (awaited_ct.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // The key may only change while the block is idle, so drain first.
   task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
      wait_for_results(SETTLE_CYCLES);
      csr_we    <= 1'b1;
      csr_index <= REG_KEY_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      csr_index <= REG_KEY_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      csr_we <= 1'b0;
      key_hi = hi;
      key_lo = lo;
   endtask

   // One message with random content: a start, perhaps some associated data
   // ending in a short block, full text blocks and a short final text block.
   // Now and then a noise transaction slips in, and one message in ten is cut
   // short so that the next start has to abandon it.
   task automatic send_random_message();
      logic [6:0]  plan[$];
      int unsigned stop_at;
      plan.push_back({OP_START, 5'($urandom_range(0, 31))});
      if ($urandom_range(0, 3) != 0) begin
         repeat ($urandom_range(0, 3)) plan.push_back({OP_AD, full_count()});
         plan.push_back({OP_AD, 5'($urandom_range(0, 15))});
      end
      repeat ($urandom_range(0, 4)) plan.push_back({OP_TEXT, full_count()});
      plan.push_back({OP_TEXT, 5'($urandom_range(0, 15))});
      stop_at = plan.size();
      if ($urandom_range(0, 9) == 0) begin
         stop_at = $urandom_range(1, plan.size() - 1);
      end
      for (int i = 0; i < stop_at; i++) begin
         if ($urandom_range(0, 19) == 0) send_noise();
         send_block(plan[i][6:5], rand64(), rand64(), plan[i][4:0]);
         well_formed_items++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   task automatic test_directed_cases();
      write_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
      // Before any start, data of either kind and the unused code are dropped.
      send_block(OP_TEXT, '1, '1, 5'd16);
      send_block(OP_AD, '1, '1, 5'd16);
      send_block(OP_UNUSED, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 5'd31);
      // A full message: full and oversized associated data, then a short final
      // block whose bytes beyond the count are all set and must be ignored.
      send_block(OP_START, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 5'd31);
      send_block(OP_AD, '1, '1, 5'd16);
      send_block(OP_AD, rand64(), rand64(), 5'd31);
      send_block(OP_AD, '1, '1, 5'd15);
      // Associated data once the message has begun is dropped.
      send_block(OP_AD, '1, '0, 5'd16);
      send_block(OP_TEXT, '0, '0, 5'd16);
      send_block(OP_TEXT, '1, '1, 5'd31);
      // An empty final block still yields an empty ciphertext before the tag.
      send_block(OP_TEXT, '1, '1, 5'd0);
      // No associated data: the first text block carries the domain separation.
      send_block(OP_START, '1, '1, 5'd0);
      send_block(OP_TEXT, rand64(), rand64(), 5'd8);
      // Associated data that is empty absorbs the padding alone.
      send_block(OP_START, '0, '0, 5'd16);
      send_block(OP_AD, '1, '1, 5'd0);
      send_block(OP_TEXT, rand64(), rand64(), 5'd7);
      // A message abandoned during its text by a fresh start.
      send_block(OP_START, rand64(), rand64(), 5'd3);
      send_block(OP_AD, rand64(), rand64(), 5'd8);
      send_block(OP_TEXT, rand64(), rand64(), 5'd16);
      // And one abandoned during its associated data.
      send_block(OP_START, rand64(), rand64(), 5'd16);
      send_block(OP_AD, rand64(), rand64(), 5'd16);
      send_block(OP_START, rand64(), rand64(), 5'd16);
      send_block(OP_AD, rand64(), rand64(), 5'd1);
      send_block(OP_TEXT, rand64(), rand64(), 5'd9);
   endtask

   // Runs a message under each extreme of the key and an alternating pattern.
   task automatic test_key_settings();
      write_key('1, '1);
      send_random_message();
      write_key('0, '0);
      send_random_message();
      write_key(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      send_random_message();
   endtask

   // The sink stops taking results for a long stretch while a long message is
   // offered, so the output register fills and the block has to stall its
   // input. Afterwards the sender waits for every result before going on.
   task automatic test_result_backpressure();
      hold_output = 1'b1;
      send_block(OP_START, rand64(), rand64(), 5'd16);
      for (int i = 0; i < 24; i++) begin
         send_block(OP_TEXT, rand64(), rand64(), full_count());
      end
      send_block(OP_TEXT, rand64(), rand64(), 5'($urandom_range(0, 15)));
      wait_for_results(SETTLE_CYCLES);
   endtask

   // The bulk of the run: random messages with noise in between, a change of
   // key every forty messages and one stretch with no idle cycles on either side.
   task automatic test_random_messages();
      int unsigned msg_idx;
      msg_idx = 0;
      while (well_formed_items < ITEM_TARGET) begin
         steady_flow = (msg_idx >= 30 && msg_idx < 50);
         if (msg_idx % 40 == 39) write_key({$urandom, $urandom}, {$urandom, $urandom});
         if ($urandom_range(0, 9) == 0) send_noise();
         send_random_message();
         msg_idx++;
      end
      steady_flow = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Result sink, checker and watchdog
   // ---------------------------------------------------------------------------

   // Drives rsp_ready at each rising edge. The long hold is counted here.
   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (hold_output) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_output = 1'b0;
         end else begin
            rsp_ready <= steady_flow || ($urandom_range(0, 99) >= 16);
         end
      end
   end

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      end
   endtask

   // Each result transaction is matched against the oldest prediction.
   always @(posedge clock) begin : result_check
      enc_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_ct.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: unexpected result, expected none, actual kind %0d %h %h %0d %0d",
                        $time, rsp_kind, rsp_out_high, rsp_out_low, rsp_out_count, rsp_last);
            end
         end else begin
            want = awaited_ct.pop_front();
            compare_field("kind", 64'(want.kind), 64'(rsp_kind));
            compare_field("out_high", want.high, rsp_out_high);
            compare_field("out_low", want.low, rsp_out_low);
            compare_field("out_count", 64'(want.count), 64'(rsp_out_count));
            compare_field("last", 64'(want.last), 64'(rsp_last));
         end
      end
   end

   // Ends the run if neither channel has moved a transaction for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = REG_KEY_HIGH;
      csr_wdata      = '0;
      req_valid      = 1'b0;
      req_op         = OP_START;
      req_word_high  = '0;
      req_word_low   = '0;
      req_byte_count = '0;
      rsp_ready      = 1'b0;
      sponge         = '0;
      msg_phase      = PHASE_IDLE;
      key_hi         = '0;
      key_lo         = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_key_settings();
      test_result_backpressure();
      test_random_messages();

      wait_for_results(TAIL_CYCLES);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/aae_pkg.sv
sv/aae_round.sv
sv/ascon_aead_encrypt.sv
dv/tb_top.sv
